// ----- design/gprc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gprc_pkg
// Types and constants of the geofence proximity check: sequencer states,
// divider jobs, register map and fixed-point constants.
// ----------------------------------------------------------------------------
package gprc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_BACK,
        ST_DIV_FIX,
        ST_LON,
        ST_FOLD,
        ST_COARSE,
        ST_HALVE,
        ST_COS_SQ,
        ST_COS_INIT,
        ST_DBL_SQ,
        ST_DBL_FIX,
        ST_LONG_LO,
        ST_LONG_HI,
        ST_LONG_SUM,
        ST_SQ_LAT,
        ST_SQ_LONG,
        ST_SQ_R,
        ST_DECIDE
    } t_state;

    // what the shared divide-by-constant sequence is working on
    typedef enum logic [1:0] {
        JOB_LAT,
        JOB_ANGLE,
        JOB_LONG
    } t_div_job;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_REF_LAT = 2'd0;
    localparam logic [1:0] REG_REF_LON = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    // raw units per metre of latitude, and per unit of angle for the cosine
    localparam logic [14:0] DIV_DIST  = 15'd66;
    localparam logic [14:0] DIV_ANGLE = 15'd25783;

    // reciprocal multiply: q = (x * RECIP) >> SHIFT, low by at most one
    localparam int SHIFT_DIST  = 37;
    localparam int SHIFT_ANGLE = 45;
    localparam logic [63:0] RECIP_DIST_W  = (64'd1 << SHIFT_DIST) / 64'(DIV_DIST);
    localparam logic [63:0] RECIP_ANGLE_W = (64'd1 << SHIFT_ANGLE) / 64'(DIV_ANGLE);
    localparam logic [30:0] RECIP_DIST    = RECIP_DIST_W[30:0];
    localparam logic [30:0] RECIP_ANGLE   = RECIP_ANGLE_W[30:0];

    localparam logic signed [33:0] HALF_TURN  = 34'sd1327104000;
    localparam logic signed [33:0] FULL_TURN  = 34'sd2654208000;
    localparam logic [30:0]        EIGHTY_DEG = 31'd589824000;
    localparam logic signed [31:0] LON_SCALE  = 32'sd330;

    localparam logic [15:0] ANGLE_MAX = 16'd4096;
    localparam logic signed [16:0] COS_ONE = 17'sd16384;

endpackage : gprc_pkg
`default_nettype wire

// ----- design/gps_radius_proximity_check_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gps_radius_proximity_check_unit
// Geofence test of a position against a reference point and a radius,
// computed on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One position is taken when start is high and busy is low; busy then stays
// high until the result is given. The cosine halves its angle a varying
// number of times: none below about 14.3 degrees of latitude, up to 3 at the
// poles, up to 4 for raw values beyond 90 degrees. A position rejected on
// latitude, on the coarse longitude bound or on scaled longitude finishes
// early. Every step goes through the single 34x32 signed multiplier, so its
// sequence of uses sets the latency. The result is o_is_close, valid in the
// single cycle o_done is high, which is the first cycle busy is low again;
// there is no way to hold it off, so it must be captured then. A new
// position may be started in that cycle.
// ----------------------------------------------------------------------------
module gps_radius_proximity_check_unit
    import gprc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [30:0] i_cur_latitude,
    input  wire logic signed [31:0] i_cur_longitude,
    output logic                    o_done,
    output logic                    o_is_close,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration
    logic signed [30:0] r_ref_lat;
    logic signed [31:0] r_ref_lon;
    logic [14:0]        r_radius;

    // control
    t_state    r_state, n_state;
    t_div_job  r_job;
    logic      r_done;
    logic      r_close;
    logic [2:0] r_n;

    // datapath
    logic [32:0]        r_x;
    logic [26:0]        r_q;
    logic signed [65:0] r_prod;
    logic [30:0]        r_lat_abs;
    logic signed [31:0] r_lon;
    logic signed [33:0] r_dlong;
    logic               r_hi_pos;
    logic [15:0]        r_a;
    logic signed [15:0] r_c;
    logic signed [32:0] r_acc;
    logic [14:0]        r_dist_lat;
    logic [14:0]        r_dist_long;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_p;
    logic               mul_en;

    logic cfg_wr;
    logic accept;
    logic fin;
    logic fin_close;

    logic signed [32:0] lat_diff;
    logic [32:0]        lat_dabs;
    logic [30:0]        lat_abs;
    logic signed [32:0] lon_diff;
    logic [32:0]        lon_abs;
    logic [14:0]        div_sel;
    logic [30:0]        recip_sel;
    logic [26:0]        q_est;
    logic [32:0]        rem;
    logic [26:0]        q_fix;
    logic               q_over;
    logic               coarse_rej;
    logic [15:0]        a_half;
    logic [24:0]        sq_rnd;
    logic signed [15:0] cos_init;
    logic [28:0]        dbl_rnd;
    logic signed [16:0] dbl_c;
    logic signed [65:0] lo_part;
    logic signed [34:0] long_sum;
    logic signed [34:0] long_neg;
    logic [32:0]        long_abs;
    logic               is_in;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign o_done     = r_done;
    assign o_is_close = r_close;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat <= '0;
            r_ref_lon <= '0;
            r_radius  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_REF_LAT: r_ref_lat <= pwdata[30:0];
                REG_REF_LON: r_ref_lon <= pwdata;
                REG_RADIUS:  r_radius  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_REF_LAT: prdata = {r_ref_lat[30], r_ref_lat};
            REG_REF_LON: prdata = r_ref_lon;
            REG_RADIUS:  prdata = {17'b0, r_radius};
            default:     prdata = '0;
        endcase
    end

    // ---------------- datapath arithmetic ----------------
    assign lat_diff = 33'(r_ref_lat) - 33'(i_cur_latitude);
    assign lat_dabs = lat_diff[32] ? 33'(-lat_diff) : 33'(lat_diff);
    assign lat_abs  = i_cur_latitude[30] ? 31'(-i_cur_latitude) : 31'(i_cur_latitude);

    assign lon_diff = 33'(r_lon) - 33'(r_ref_lon);
    assign lon_abs  = lon_diff[32] ? 33'(-lon_diff) : 33'(lon_diff);

    assign div_sel   = (r_job == JOB_ANGLE) ? DIV_ANGLE : DIV_DIST;
    assign recip_sel = (r_job == JOB_ANGLE) ? RECIP_ANGLE : RECIP_DIST;
    assign q_est     = (r_job == JOB_ANGLE)
                     ? {11'b0, r_prod[SHIFT_ANGLE+15:SHIFT_ANGLE]}
                     : r_prod[SHIFT_DIST+26:SHIFT_DIST];

    // reciprocal estimate is exact or one short
    assign rem    = r_x - r_prod[32:0];
    assign q_fix  = r_q + 27'(rem >= {18'b0, div_sel});
    assign q_over = (q_fix > {12'b0, r_radius});

    assign coarse_rej = (r_lat_abs < EIGHTY_DEG)
                     && (r_dlong > $signed({10'b0, r_prod[23:0]}));

    assign a_half   = 16'(({1'b0, r_a} + 17'd1) >> 1);
    assign sq_rnd   = r_prod[24:0] + 25'd16384;
    assign cos_init = 16'(COS_ONE - $signed({7'b0, sq_rnd[24:15]}));
    assign dbl_rnd  = r_prod[28:0] + 29'd4096;
    assign dbl_c    = $signed({1'b0, dbl_rnd[28:13]}) - COS_ONE;

    assign lo_part  = r_prod >>> 14;
    assign long_sum = 35'(r_acc) + $signed(r_prod[34:0]);
    assign long_neg = -long_sum;
    assign long_abs = long_sum[34] ? long_neg[32:0] : long_sum[32:0];

    assign is_in = (r_acc <= $signed(r_prod[32:0]));

    assign mul_p = mul_a * mul_b;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (start) n_state = ST_DIV_MUL;
            ST_DIV_MUL:  n_state = ST_DIV_BACK;
            ST_DIV_BACK: n_state = ST_DIV_FIX;
            ST_DIV_FIX: begin
                case (r_job)
                    JOB_LAT:   n_state = q_over ? ST_IDLE : ST_LON;
                    JOB_ANGLE: n_state = ST_HALVE;
                    JOB_LONG:  n_state = q_over ? ST_IDLE : ST_SQ_LAT;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_LON:      n_state = ST_FOLD;
            ST_FOLD:     n_state = ST_COARSE;
            ST_COARSE:   n_state = coarse_rej ? ST_IDLE : ST_DIV_MUL;
            ST_HALVE:    n_state = (r_a > ANGLE_MAX) ? ST_HALVE : ST_COS_SQ;
            ST_COS_SQ:   n_state = ST_COS_INIT;
            ST_COS_INIT: n_state = (r_n != 3'd0) ? ST_DBL_SQ : ST_LONG_LO;
            ST_DBL_SQ:   n_state = ST_DBL_FIX;
            ST_DBL_FIX:  n_state = (r_n == 3'd1) ? ST_LONG_LO : ST_DBL_SQ;
            ST_LONG_LO:  n_state = ST_LONG_HI;
            ST_LONG_HI:  n_state = ST_LONG_SUM;
            ST_LONG_SUM: n_state = ST_DIV_MUL;
            ST_SQ_LAT:   n_state = ST_SQ_LONG;
            ST_SQ_LONG:  n_state = ST_SQ_R;
            ST_SQ_R:     n_state = ST_DECIDE;
            ST_DECIDE:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_en    = 1'b0;
        fin       = 1'b0;
        fin_close = 1'b0;
        case (r_state)
            ST_DIV_MUL: begin
                mul_a  = $signed({1'b0, r_x});
                mul_b  = $signed({1'b0, recip_sel});
                mul_en = 1'b1;
            end
            ST_DIV_BACK: begin
                mul_a  = $signed({7'b0, q_est});
                mul_b  = $signed({17'b0, div_sel});
                mul_en = 1'b1;
            end
            ST_DIV_FIX: fin = (r_job != JOB_ANGLE) && q_over;
            ST_LON: begin
                mul_a  = $signed({19'b0, r_radius});
                mul_b  = LON_SCALE;
                mul_en = 1'b1;
            end
            ST_COARSE: fin = coarse_rej;
            ST_COS_SQ: begin
                mul_a  = $signed({18'b0, r_a});
                mul_b  = $signed({16'b0, r_a});
                mul_en = 1'b1;
            end
            ST_DBL_SQ: begin
                mul_a  = 34'(r_c);
                mul_b  = 32'(r_c);
                mul_en = 1'b1;
            end
            ST_LONG_LO: begin
                mul_a  = $signed({20'b0, r_dlong[13:0]});
                mul_b  = 32'(r_c);
                mul_en = 1'b1;
            end
            ST_LONG_HI: begin
                mul_a  = r_dlong >>> 14;
                mul_b  = 32'(r_c);
                mul_en = 1'b1;
            end
            ST_SQ_LAT: begin
                mul_a  = $signed({19'b0, r_dist_lat});
                mul_b  = $signed({17'b0, r_dist_lat});
                mul_en = 1'b1;
            end
            ST_SQ_LONG: begin
                mul_a  = $signed({19'b0, r_dist_long});
                mul_b  = $signed({17'b0, r_dist_long});
                mul_en = 1'b1;
            end
            ST_SQ_R: begin
                mul_a  = $signed({19'b0, r_radius});
                mul_b  = $signed({17'b0, r_radius});
                mul_en = 1'b1;
            end
            ST_DECIDE: begin
                fin       = 1'b1;
                fin_close = is_in;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= fin;
            r_close <= fin_close;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_job <= JOB_LAT;
        end else begin
            case (r_state)
                ST_IDLE: if (accept) r_job <= JOB_LAT;
                ST_DIV_FIX: if (r_job == JOB_ANGLE) r_n <= '0;
                ST_COARSE: r_job <= JOB_ANGLE;
                ST_HALVE: if (r_a > ANGLE_MAX) r_n <= r_n + 3'd1;
                ST_DBL_FIX: r_n <= r_n - 3'd1;
                ST_LONG_SUM: r_job <= JOB_LONG;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_x       <= lat_dabs;
                    r_lat_abs <= lat_abs;
                    r_lon     <= i_cur_longitude;
                end
            end
            ST_DIV_BACK: r_q <= q_est;
            ST_DIV_FIX: begin
                case (r_job)
                    JOB_LAT:   r_dist_lat  <= q_fix[14:0];
                    JOB_ANGLE: r_a         <= q_fix[15:0];
                    JOB_LONG:  r_dist_long <= q_fix[14:0];
                    default: ;
                endcase
            end
            ST_LON: begin
                r_dlong  <= $signed({1'b0, lon_abs});
                r_hi_pos <= (r_lon > 32'sd0) || (r_ref_lon > 32'sd0);
            end
            ST_FOLD: begin
                // across the 180 degree line
                if (r_hi_pos && (r_dlong > HALF_TURN)) r_dlong <= FULL_TURN - r_dlong;
            end
            ST_COARSE:   r_x <= {2'b0, r_lat_abs};
            ST_HALVE:    if (r_a > ANGLE_MAX) r_a <= a_half;
            ST_COS_INIT: r_c <= cos_init;
            ST_DBL_FIX:  r_c <= dbl_c[15:0];
            ST_LONG_HI:  r_acc <= lo_part[32:0];
            ST_LONG_SUM: r_x <= long_abs;
            ST_SQ_LONG:  r_acc <= $signed(r_prod[32:0]);
            ST_SQ_R:     r_acc <= r_acc + $signed(r_prod[32:0]);
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_done))
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_dbl_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LONG_LO) |-> (r_n == 3'd0))
        else $error("cosine doubling count not exhausted");

endmodule : gps_radius_proximity_check_unit
`default_nettype wire

// ----- dv/proximity_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_checker
// Watches the position, result and register ports of the geofence unit,
// predicts the closeness flag of every accepted position from its own copy
// of the reference point and radius, and compares each result beat with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module proximity_checker
    import gprc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic signed [30:0] i_cur_latitude,
    input  wire logic signed [31:0] i_cur_longitude,
    input  wire logic               i_done,
    input  wire logic               i_is_close,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [3:0]         i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam longint RAW_PER_METRE   = 66;
    localparam longint RAW_PER_RADIAN  = 25783;   // Q14 radians
    localparam longint ANGLE_LIMIT     = 4096;
    localparam longint COS_UNITY       = 16384;
    localparam longint HALF_TURN_RAW   = 1327104000;
    localparam longint EIGHTY_DEG_RAW  = 589824000;
    localparam longint COARSE_PER_M    = 330;

    typedef struct {
        logic               close;
        logic signed [30:0] lat;
        logic signed [31:0] lon;
    } t_close_due;

    t_close_due         closeness_due[$];
    logic signed [30:0] mirror_lat    = '0;
    logic signed [31:0] mirror_lon    = '0;
    logic [14:0]        mirror_radius = '0;
    int                 mismatches    = 0;

    // cosine of a raw latitude, Q14, by halving and re-doubling the angle
    function automatic longint cos_q14(input longint lat);
        longint a;
        longint c;
        int     halvings;
        a = (lat < 0 ? -lat : lat) / RAW_PER_RADIAN;
        halvings = 0;
        while (a > ANGLE_LIMIT) begin
            a = (a + 1) / 2;
            halvings++;
        end
        c = COS_UNITY - ((a * a + COS_UNITY) >>> 15);
        repeat (halvings) c = ((c * c + 4096) >>> 13) - COS_UNITY;
        return c;
    endfunction

    function automatic logic geofence_close(input longint cur_lat, input longint cur_lon,
                                            input longint fence_lat, input longint fence_lon,
                                            input longint rad);
        longint dlat;
        longint dist_lat;
        longint lo;
        longint hi;
        longint swap;
        longint dlong;
        longint c;
        longint low_bits;
        longint dist_long;
        dlat = fence_lat - cur_lat;
        if (dlat < 0) dlat = -dlat;
        dist_lat = dlat / RAW_PER_METRE;
        if (dist_lat > rad) return 1'b0;
        lo = cur_lon;
        hi = fence_lon;
        if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        // fold across the 180 degree line
        if (hi > 0 && lo < hi - HALF_TURN_RAW) begin
            swap = lo + HALF_TURN_RAW;
            lo = hi - HALF_TURN_RAW;
            hi = swap;
        end
        dlong = hi - lo;
        if ((cur_lat < 0 ? -cur_lat : cur_lat) < EIGHTY_DEG_RAW && dlong > COARSE_PER_M * rad)
            return 1'b0;
        c = cos_q14(cur_lat);
        low_bits = dlong & 64'sh3FFF;
        // >>> floors, / truncates toward zero
        dist_long = (((low_bits * c) >>> 14) + ((dlong >>> 14) * c)) / RAW_PER_METRE;
        if (dist_long > rad) return 1'b0;
        return (dist_lat * dist_lat + dist_long * dist_long <= rad * rad);
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_close_due due;
        if (!i_rst_n) begin
            closeness_due.delete();
            mirror_lat    = '0;
            mirror_lon    = '0;
            mirror_radius = '0;
        end else begin
            if (i_done) begin
                if (closeness_due.size() == 0) begin
                    note_failure($sformatf("result beat is_close=%0b with none expected",
                                           i_is_close));
                end else begin
                    due = closeness_due.pop_front();
                    if (i_is_close !== due.close)
                        note_failure($sformatf(
                            "is_close expected %0b got %0b (lat %0d lon %0d)",
                            due.close, i_is_close, due.lat, due.lon));
                end
            end
            if (i_start && !i_busy) begin
                due.lat   = i_cur_latitude;
                due.lon   = i_cur_longitude;
                due.close = geofence_close(longint'(i_cur_latitude),
                                           longint'(i_cur_longitude),
                                           longint'(mirror_lat), longint'(mirror_lon),
                                           longint'(mirror_radius));
                closeness_due.push_back(due);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_REF_LAT: mirror_lat    = i_pwdata[30:0];
                    REG_REF_LON: mirror_lon    = i_pwdata;
                    REG_RADIUS:  mirror_radius = i_pwdata[14:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= closeness_due.size();
        o_fail_count <= mismatches;
    end

endmodule : proximity_checker

// ----- dv/tb_gps_radius_proximity_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gps_radius_proximity_check_unit
// Drives positions and reference settings into the geofence unit: a directed
// pass over boundaries, the 180 degree fold, high and beyond-pole latitudes
// and zero radius, then random positions clustered around random reference
// points, sent in bursts with random gaps. The checker beside the unit
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gps_radius_proximity_check_unit
    import gprc_pkg::*;
();

    localparam longint LAT_LIMIT      = 663552000;
    localparam longint LON_LIMIT      = 1327104000;
    localparam longint EIGHTY_DEG_RAW = 589824000;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic signed [30:0] i_cur_latitude  = '0;
    logic signed [31:0] i_cur_longitude = '0;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [3:0]         paddr           = '0;
    logic [31:0]        pwdata          = '0;
    logic               busy;
    logic               o_done;
    logic               o_is_close;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 burst_left      = 0;
    longint             fence_lat       = 0;
    longint             fence_lon       = 0;
    longint             fence_radius    = 0;

    gps_radius_proximity_check_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cur_latitude  (i_cur_latitude),
        .i_cur_longitude (i_cur_longitude),
        .o_done          (o_done),
        .o_is_close      (o_is_close),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    proximity_checker u_proximity_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cur_latitude  (i_cur_latitude),
        .i_cur_longitude (i_cur_longitude),
        .i_done          (o_done),
        .i_is_close      (o_is_close),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic longint around_zero(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // one position beat; idles between some bursts
    task automatic send_fix(input longint lat, input longint lon);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_cur_latitude  <= lat[30:0];
        i_cur_longitude <= lon[31:0];
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input longint lat, input longint lon, input longint rad);
        drain();
        repeat (3) @(posedge i_clk);
        write_reg(REG_REF_LAT, 32'(lat));
        write_reg(REG_REF_LON, 32'(lon));
        write_reg(REG_RADIUS, 32'(rad));
        fence_lat    = lat;
        fence_lon    = lon;
        fence_radius = rad;
    endtask

    task automatic random_config();
        longint      lat;
        longint      lon;
        longint      rad;
        logic [30:0] raw_lat;
        case ($urandom_range(0, 4))
            0: lat = LAT_LIMIT;
            1: lat = -LAT_LIMIT;
            2: begin
                raw_lat = 31'($urandom);
                lat = longint'($signed(raw_lat));
            end
            default: lat = around_zero(LAT_LIMIT);
        endcase
        case ($urandom_range(0, 4))
            0: lon = LON_LIMIT;
            1: lon = -LON_LIMIT;
            2: lon = longint'(int'($urandom));
            default: lon = around_zero(LON_LIMIT);
        endcase
        case ($urandom_range(0, 4))
            0: rad = 0;
            1: rad = 32767;
            2: rad = $urandom_range(1, 60);
            default: rad = $urandom_range(0, 32767);
        endcase
        set_config(lat, lon, rad);
    endtask

    task automatic random_fix();
        longint      lat;
        longint      lon;
        longint      lat_span;
        longint      lon_span;
        logic [30:0] raw_lat;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // around the reference; longitude span up to 16 times wider, for high latitudes
            lat_span = (fence_radius + 3) * 66 * (1 + $urandom_range(0, 1));
            lon_span = (fence_radius + 3) * 66 * (longint'(1) << $urandom_range(0, 4));
            lat = fence_lat + around_zero(lat_span);
            lon = fence_lon + around_zero(lon_span);
            if ($urandom_range(0, 1) == 1) begin
                if (lon > LON_LIMIT) lon -= 2 * LON_LIMIT;
                else if (lon < -LON_LIMIT) lon += 2 * LON_LIMIT;
            end
        end else if (pick < 85) begin
            lat = around_zero(LAT_LIMIT);
            lon = around_zero(LON_LIMIT);
        end else begin
            raw_lat = 31'($urandom);
            lat = longint'($signed(raw_lat));
            lon = longint'(int'($urandom));
        end
        send_fix(lat, lon);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: origin, zero radius
        send_fix(0, 0);
        send_fix(65, 0);
        send_fix(66, 0);
        send_fix(0, 1);

        // latitude and longitude boundaries, final squared-distance compare
        set_config(0, 0, 1000);
        send_fix(66000, 0);
        send_fix(66066, 0);
        send_fix(-66000, 0);
        send_fix(0, 330000);
        send_fix(0, 66000);
        send_fix(0, 66067);
        send_fix(46000, 46000);
        send_fix(47000, 47000);

        // fold across 180 degrees, coarse bound skipped above 80 degrees
        set_config(EIGHTY_DEG_RAW + 1000000, LON_LIMIT, 32767);
        send_fix(EIGHTY_DEG_RAW + 1000000, -LON_LIMIT);
        send_fix(EIGHTY_DEG_RAW + 1000000, -LON_LIMIT + 5000000);
        send_fix(EIGHTY_DEG_RAW + 10, LON_LIMIT - 11000000);
        send_fix(EIGHTY_DEG_RAW - 10, LON_LIMIT - 11000000);

        // beyond the pole: negative cosine, negative longitude distance
        set_config(700000000, -LON_LIMIT, 32767);
        send_fix(700000000, -LON_LIMIT + 1000000);
        send_fix(700000000, 2147483647);
        send_fix(-1073741824, -2147483648);
        send_fix(1073741823, -2147483648);
        send_fix(LAT_LIMIT, LON_LIMIT);
        send_fix(-LAT_LIMIT, -LON_LIMIT);

        // zero radius at the south-west corner
        set_config(-LAT_LIMIT, -LON_LIMIT, 0);
        send_fix(-LAT_LIMIT, -LON_LIMIT);
        send_fix(-LAT_LIMIT + 65, -LON_LIMIT);
        send_fix(-LAT_LIMIT, -LON_LIMIT + 1);
        send_fix(-LAT_LIMIT, LON_LIMIT);

        for (int ph = 0; ph < 12; ph++) begin
            random_config();
            for (int k = 0; k < 94; k++) begin
                if (ph == 3 && k == 47) drain();
                random_fix();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule : tb_gps_radius_proximity_check_unit
